[src/bhp_pkg.sv]
// Package for the fourth-order high-pass IIR core.
// Holds fixed-point constants, feedback coefficients and the queue status type.
// No dependencies.
`default_nettype none

package bhp_pkg;

  // input scaling: round(2^30 / gain)
  localparam int INV_GAIN_Q30 = 788564584;
  localparam int COEF_FRAC    = 28;
  localparam int OUT_SCALE    = 32767;
  localparam int SAMPLE_W     = 16;

  // feedback coefficients, Q28, oldest output first
  localparam logic signed [31:0] FB_COEF [4] = '{
    -32'sd144782040, 32'sd668172973, -32'sd1164221167, 32'sd908646698
  };

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } bhp_qstat_t;

endpackage

`default_nettype wire

[src/bhp_front.sv]
// Front stage: accepts input transactions and scales each sample to the
// state format. Depends on bhp_pkg.
`default_nettype none

module bhp_front import bhp_pkg::*; #(
  parameter int STATE_WIDTH = 32
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_tvalid,
  output logic                     in_tready,
  input  wire  [15:0]              in_tdata,   // [15:0] sample_in
  input  wire                      in_tlast,   // block_end
  output logic                     q_valid,
  input  wire                      q_ready,
  output logic [STATE_WIDTH:0]     q_data      // {block_end, scaled sample}
);

  localparam int FRAC_BITS = STATE_WIDTH - 4;
  localparam int SH        = 45 - FRAC_BITS;
  localparam logic signed [47:0] GAIN48 = 48'(INV_GAIN_Q30);
  localparam logic signed [47:0] RND48  = 48'sd1 <<< (SH - 1);

  logic signed [47:0]            samp_ext;
  logic signed [47:0]            prod;
  logic signed [47:0]            rounded;
  logic signed [STATE_WIDTH-1:0] x_nxt;
  logic signed [STATE_WIDTH-1:0] x_r;
  logic                          last_r;
  logic                          v_r;
  logic                          v_nxt;
  logic                          take;

  always_comb begin
    samp_ext = {{(48-SAMPLE_W){in_tdata[SAMPLE_W-1]}}, in_tdata};
    prod     = samp_ext * GAIN48;
    rounded  = (prod + RND48) >>> SH;
    x_nxt    = rounded[STATE_WIDTH-1:0];
  end

  assign in_tready = !v_r || q_ready;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    v_nxt = v_r;
    if (take) begin
      v_nxt = 1'b1;
    end else if (q_ready) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      x_r    <= x_nxt;
      last_r <= in_tlast;
    end
  end

  assign q_valid = v_r;
  assign q_data  = {last_r, x_r};

endmodule

`default_nettype wire

[src/bhp_queue.sv]
// Short register queue between front and back stages (first-word fall-through).
// Depends on bhp_pkg for depth and status type.
`default_nettype none

module bhp_queue import bhp_pkg::*; #(
  parameter int WIDTH = 33
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              wr_valid,
  output logic             wr_ready,
  input  wire  [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  wire              rd_ready,
  output logic [WIDTH-1:0] rd_data,
  output bhp_qstat_t       stat
);

  logic [WIDTH-1:0]  mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push, pop;

  assign wr_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_comb begin
    stat.push  = push;
    stat.pop   = pop;
    stat.full  = !wr_ready;
    stat.empty = !rd_valid;
    stat.count = cnt_r;
  end

endmodule

`default_nettype wire

[src/bhp_back.sv]
// Back stage: IIR recurrence over input/output history, then output scaling,
// truncation and saturation into the output register. Depends on bhp_pkg.
`default_nettype none

module bhp_back import bhp_pkg::*; #(
  parameter int STATE_WIDTH = 32
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      q_valid,
  output logic                     q_ready,
  input  wire  [STATE_WIDTH:0]     q_data,     // {block_end, scaled sample}
  output logic                     out_tvalid,
  input  wire                      out_tready,
  output logic [15:0]              out_tdata,  // [15:0] sample_out
  output logic                     out_tlast   // block_end_out
);

  localparam int W         = STATE_WIDTH;
  localparam int FRAC_BITS = W - 4;
  localparam int SUMW      = W + 6;
  localparam int PW        = W + 32;
  localparam int OW        = W + 17;
  localparam logic signed [PW-1:0] RND_C      = PW'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [OW-1:0] SCALE_O    = OW'(OUT_SCALE);
  localparam logic signed [OW-1:0] TRUNC_BIAS = OW'((64'd1 << FRAC_BITS) - 64'd1);

  logic signed [W-1:0]    xh_r [4];
  logic signed [W-1:0]    yh_r [4];
  logic signed [W-1:0]    x_in;
  logic signed [SUMW-1:0] ff;
  logic signed [SUMW-1:0] fb;
  logic signed [SUMW-1:0] acc;
  logic signed [PW-1:0]   prod [4];
  logic signed [PW-1:0]   rnd  [4];
  logic signed [W-1:0]    y_nxt;

  logic                   yv_r, yv_nxt;
  logic signed [W-1:0]    y_r;
  logic                   ylast_r;
  logic                   a_take, b_take;

  logic signed [OW-1:0]   p;
  logic signed [OW-1:0]   q;
  logic [15:0]            o_nxt;
  logic                   outv_r, outv_nxt;
  logic [15:0]            out_data_r;
  logic                   out_last_r;

  assign x_in = q_data[W-1:0];

  always_comb begin
    ff = SUMW'(x_in) + SUMW'(xh_r[3])
       - SUMW'(4) * (SUMW'(xh_r[0]) + SUMW'(xh_r[2]))
       + SUMW'(6) * SUMW'(xh_r[1]);
    fb = '0;
    // coefficient k pairs with output history entry 3-k
    for (int k = 0; k < 4; k++) begin
      prod[k] = {{32{yh_r[3-k][W-1]}}, yh_r[3-k]} * {{W{FB_COEF[k][31]}}, FB_COEF[k]};
      rnd[k]  = (prod[k] + RND_C) >>> COEF_FRAC;
      fb      = fb + rnd[k][SUMW-1:0];
    end
    acc = ff + fb;
    if (acc[SUMW-1:W-1] == '0 || acc[SUMW-1:W-1] == '1) begin
      y_nxt = acc[W-1:0];
    end else if (acc[SUMW-1]) begin
      y_nxt = {1'b1, {(W-1){1'b0}}};
    end else begin
      y_nxt = {1'b0, {(W-1){1'b1}}};
    end
  end

  assign b_take  = yv_r && (!outv_r || out_tready);
  assign q_ready = !yv_r || b_take;
  assign a_take  = q_valid && q_ready;

  always_comb begin
    yv_nxt = yv_r;
    if (a_take) begin
      yv_nxt = 1'b1;
    end else if (b_take) begin
      yv_nxt = 1'b0;
    end
    outv_nxt = outv_r;
    if (b_take) begin
      outv_nxt = 1'b1;
    end else if (out_tready) begin
      outv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yv_r   <= 1'b0;
      outv_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        xh_r[i] <= '0;
        yh_r[i] <= '0;
      end
    end else begin
      yv_r   <= yv_nxt;
      outv_r <= outv_nxt;
      if (a_take) begin
        for (int i = 3; i > 0; i--) begin
          xh_r[i] <= xh_r[i-1];
          yh_r[i] <= yh_r[i-1];
        end
        xh_r[0] <= x_in;
        yh_r[0] <= y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      y_r     <= y_nxt;
      ylast_r <= q_data[W];
    end
  end

  // scale by 32767, truncate toward zero, saturate to 16 bits
  always_comb begin
    p = {{17{y_r[W-1]}}, y_r} * SCALE_O;
    q = (p[OW-1] ? (p + TRUNC_BIAS) : p) >>> FRAC_BITS;
    if (q[OW-1:15] == '0 || q[OW-1:15] == '1) begin
      o_nxt = q[15:0];
    end else if (q[OW-1]) begin
      o_nxt = 16'h8000;
    end else begin
      o_nxt = 16'h7fff;
    end
  end

  always_ff @(posedge clk) begin
    if (b_take) begin
      out_data_r <= o_nxt;
      out_last_r <= ylast_r;
    end
  end

  assign out_tvalid = outv_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

[src/butterworth_highpass_order4_core.sv]
// Fourth-order high-pass IIR core, top level: front scaler, queue, back filter.
// Path: an accepted sample passes the front register, the queue, the back-stage state register and the output register.
// Throughput: one sample per clock while out_tready is not held low, bounded by the feedback loop
// (four coefficient products summed into the new output).
// Reset (synchronous, rst_n low): clears filter history, queue and valid flags.
// Depends on bhp_pkg, bhp_front, bhp_queue, bhp_back.
`default_nettype none

module butterworth_highpass_order4_core import bhp_pkg::*; #(
  parameter int STATE_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,    // [15:0] sample_in
  input  wire         in_tlast,    // block_end
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,   // [15:0] sample_out
  output logic        out_tlast    // block_end_out
);

  logic                 fq_valid, fq_ready;
  logic [STATE_WIDTH:0] fq_data;
  logic                 qb_valid, qb_ready;
  logic [STATE_WIDTH:0] qb_data;
  bhp_qstat_t           q_stat;

  bhp_front #(.STATE_WIDTH(STATE_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_data    (fq_data)
  );

  bhp_queue #(.WIDTH(STATE_WIDTH + 1)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data),
    .stat     (q_stat)
  );

  bhp_back #(.STATE_WIDTH(STATE_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_data     (qb_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_qcount_max: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");

  a_qcount_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.push && !q_stat.pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
    else $error("queue count did not follow push");

  a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !q_stat.push)
    else $error("push into full queue");

  a_empty_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !q_stat.pop)
    else $error("pop from empty queue");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire

[test/butterworth_highpass_order4_core_test.sv]
// Testbench for butterworth_highpass_order4_core: stream in samples, predict each filtered
// sample with a fixed-point model of the filter, and check every output transaction.
// Depends only on the core RTL and its package (src/).
`default_nettype none

module butterworth_highpass_order4_core_test;

  localparam int STATE_W   = 32;
  localparam int FRAC_W    = STATE_W - 4;
  localparam int SCALE_SH  = 45 - FRAC_W;
  localparam longint INV_GAIN = 64'sd788564584;
  localparam int COEF_W    = 28;
  localparam longint OUT_GAIN = 64'sd32767;
  localparam longint STATE_MAX = (64'sd1 <<< (STATE_W - 1)) - 1;
  localparam longint STATE_MIN = -STATE_MAX - 1;
  // feedback taps, Q28, applied to the oldest stored output first
  localparam longint FB_TAP [4] = '{
    -64'sd144782040, 64'sd668172973, -64'sd1164221167, 64'sd908646698
  };
  localparam int HOLD_OFF_CYCLES = 80;

  typedef struct {
    logic signed [15:0] sample;
    logic               last;
  } filt_res_t;

  typedef enum int {MODE_NOISE, MODE_NYQUIST, MODE_QUIET, MODE_DC} stim_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;    // [15:0] sample_in
  logic        in_tlast = 1'b0;  // block_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // [15:0] sample_out
  logic        out_tlast;        // block_end_out

  butterworth_highpass_order4_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // filter history, index 0 newest
  logic signed [STATE_W-1:0] x_hist [4] = '{default: '0};
  logic signed [STATE_W-1:0] y_hist [4] = '{default: '0};

  filt_res_t filtered_q [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_len     = 0;
  int error_count   = 0;
  int sample_count  = 0;
  int result_count  = 0;
  int block_ends    = 0;
  int clipped_count = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic filt_res_t highpass_step(input logic signed [15:0] s, input logic last);
    longint    xs, ff, fb, y, p, o;
    filt_res_t r;
    xs = (longint'(s) * INV_GAIN + (64'sd1 <<< (SCALE_SH - 1))) >>> SCALE_SH;
    ff = xs + longint'(x_hist[3]) - 4 * (longint'(x_hist[0]) + longint'(x_hist[2]))
       + 6 * longint'(x_hist[1]);
    fb = 0;
    for (int k = 0; k < 4; k++)
      fb += (longint'(y_hist[3-k]) * FB_TAP[k] + (64'sd1 <<< (COEF_W - 1))) >>> COEF_W;
    y = ff + fb;
    if (y > STATE_MAX) y = STATE_MAX;
    if (y < STATE_MIN) y = STATE_MIN;
    for (int k = 3; k > 0; k--) begin
      x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    x_hist[0] = xs[STATE_W-1:0];
    y_hist[0] = y[STATE_W-1:0];
    // scale to 16 bits, truncating toward zero
    p = y * OUT_GAIN;
    o = (p < 0) ? -((-p) >>> FRAC_W) : (p >>> FRAC_W);
    if (o > 32767) o = 32767;
    if (o < -32768) o = -32768;
    if (o == 32767 || o == -32768) clipped_count++;
    r.sample = o[15:0];
    r.last   = last;
    return r;
  endfunction

  // returns at the accepting edge with tvalid still high
  task automatic send_sample(input logic signed [15:0] s, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    filtered_q.push_back(highpass_step(s, last));
    sample_count++;
    if (last) block_ends++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic drain_results();
    stop_sending();
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // receiver: random backpressure, or a counted hold-off when requested
  always @(negedge clk) begin
    if (stall_len != 0) begin
      out_tready <= 1'b0;
      stall_len = stall_len - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    filt_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      result_count++;
      if (filtered_q.size() == 0) begin
        report_mismatch("unexpected output transaction", int'($signed(out_tdata)), 0);
      end else begin
        want = filtered_q.pop_front();
        if (out_tdata !== want.sample)
          report_mismatch("sample_out", int'($signed(out_tdata)), int'(want.sample));
        if (out_tlast !== want.last)
          report_mismatch("block_end_out", int'(out_tlast), int'(want.last));
      end
    end
  end

  task automatic test_extremes();
    send_sample(16'sd0, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd1, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    stop_sending();
  endtask

  // full-scale alternation sits at the top of the passband: drives output clipping
  task automatic test_nyquist_burst();
    for (int i = 0; i < 12; i++)
      send_sample((i % 2 == 0) ? 16'sh7fff : 16'sh8000, i == 11);
    stop_sending();
  endtask

  task automatic test_step();
    for (int i = 0; i < 6; i++)
      send_sample(16'sh8000, i == 5);
    stop_sending();
  endtask

  task automatic test_random_stream(input int n, input int snd_idle, input int rcv_idle);
    int                 left, run;
    stim_mode_t         mode;
    logic signed [15:0] v, dc;
    send_idle_pct = snd_idle;
    recv_idle_pct = rcv_idle;
    left = n;
    while (left > 0) begin
      mode = stim_mode_t'($urandom_range(3));
      run  = $urandom_range(1, 16);
      if (run > left) run = left;
      dc = 16'($urandom);
      for (int i = 0; i < run; i++) begin
        case (mode)
          MODE_NOISE:   v = 16'($urandom);
          MODE_NYQUIST: v = ((i % 2 == 0) ^ dc[0]) ? 16'sh7fff : 16'sh8000;
          MODE_QUIET:   v = 16'($urandom_range(512)) - 16'd256;
          default:      v = dc;
        endcase
        send_sample(v, $urandom_range(7) == 0);
      end
      left -= run;
    end
    drain_results();
  endtask

  // hold the output off long enough that the core fills and stalls its input
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    stall_len = HOLD_OFF_CYCLES;
    for (int i = 0; i < 30; i++)
      send_sample(16'($urandom), $urandom_range(7) == 0);
    drain_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_nyquist_burst();
    test_step();
    drain_results();
    test_random_stream(135, 17, 66);
    test_random_stream(135, 66, 17);
    test_random_stream(135, 0, 0);
    test_output_hold_off();
    $display("covered %0d samples, %0d results, %0d block ends, %0d clipped outputs",
             sample_count, result_count, block_ends, clipped_count);
    $display("stalls on both sides plus an %0d-cycle output hold-off; %0d mismatches",
             HOLD_OFF_CYCLES, error_count);
    if (error_count == 0)
      $display("butterworth_highpass_order4_core_test: PASS");
    else
      $display("butterworth_highpass_order4_core_test: FAIL");
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout with %0d results outstanding", filtered_q.size());
    $display("butterworth_highpass_order4_core_test: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
